// File: sv/sbc_pkg.sv
// Shared types and codes of the sphere/box classifier.
package sbc_pkg;

    typedef enum logic [1:0] {
        REL_OUTSIDE    = 2'd0,
        REL_INTERSECTS = 2'd1,
        REL_INSIDE     = 2'd2
    } relation_t;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_RADIUS    = 3'd3;
    localparam logic [2:0] REG_FAST_MODE = 3'd4;

endpackage

// File: sv/sphere_box_classify.sv
// Top level: pipelined classification of axis-aligned boxes against a sphere.
//
// One box word is taken on every cycle that start is high; busy is never raised.
// Each word gives one relation word, marked by done, after five register stages
// (difference, clamp/far select, squares, sums, compare); words leave in the order
// they came. The receiver cannot stall the result. The far-corner test uses the
// sum over axes of the larger squared corner distance, which is the maximum over
// all eight corners. Write the sphere registers only while no word is in flight;
// the squared radius is registered from the radius register and settles after it.
module sphere_box_classify #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [2:0]                    cfg_idx,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_WIDTH-1:0]        box_min_x,
    input  logic [COORD_WIDTH-1:0]        box_min_y,
    input  logic [COORD_WIDTH-1:0]        box_min_z,
    input  logic [COORD_WIDTH-1:0]        box_max_x,
    input  logic [COORD_WIDTH-1:0]        box_max_y,
    input  logic [COORD_WIDTH-1:0]        box_max_z,
    output logic                          done,
    output logic [1:0]                    relation
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int SUM_W = SQ_W + 2;
    localparam int RW    = CW - 1;
    localparam int RSQ_W = 2 * RW;

    logic [CW-1:0]    center_reg [3];
    logic [RW-1:0]    radius_reg;
    logic             fast_mode_reg;
    logic [RSQ_W-1:0] rsq_reg;

    logic [CW-1:0]    lo_in [3];
    logic [CW-1:0]    hi_in [3];

    logic             v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic [DW-1:0]    dlo1_reg [3];
    logic [DW-1:0]    dhi1_reg [3];
    logic [DW-1:0]    gap2_next [3];
    logic [DW-1:0]    far2_next [3];
    logic [DW-1:0]    gap2_reg [3];
    logic [DW-1:0]    far2_reg [3];
    logic [SQ_W-1:0]  gsq3_reg [3];
    logic [SQ_W-1:0]  fsq3_reg [3];
    logic [SUM_W-1:0] dsq4_reg;
    logic [SUM_W-1:0] lsq4_reg;
    sbc_pkg::relation_t relation_next;
    sbc_pkg::relation_t relation_reg;

    assign lo_in[0] = box_min_x;
    assign lo_in[1] = box_min_y;
    assign lo_in[2] = box_min_z;
    assign hi_in[0] = box_max_x;
    assign hi_in[1] = box_max_y;
    assign hi_in[2] = box_max_z;

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign relation = relation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= '0;
            fast_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                sbc_pkg::REG_CENTER_X:  center_reg[0] <= cfg_data;
                sbc_pkg::REG_CENTER_Y:  center_reg[1] <= cfg_data;
                sbc_pkg::REG_CENTER_Z:  center_reg[2] <= cfg_data;
                sbc_pkg::REG_RADIUS:    radius_reg    <= cfg_data[RW-1:0];
                sbc_pkg::REG_FAST_MODE: fast_mode_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Clamp gap and far-corner distance per axis
    always_comb
    begin
        logic [DW-1:0] alo;
        logic [DW-1:0] ahi;
        logic          above;
        for (int k = 0; k < 3; k++)
        begin
            alo   = dlo1_reg[k][DW-1] ? (~dlo1_reg[k] + 1'b1) : dlo1_reg[k];
            ahi   = dhi1_reg[k][DW-1] ? (~dhi1_reg[k] + 1'b1) : dhi1_reg[k];
            above = !dhi1_reg[k][DW-1] && (dhi1_reg[k] != '0);
            priority if (dlo1_reg[k][DW-1])
                gap2_next[k] = alo;
            else if (above)
                gap2_next[k] = ahi;
            else
                gap2_next[k] = '0;
            far2_next[k] = (alo >= ahi) ? alo : ahi;
        end
    end

    always_comb
    begin
        priority if (dsq4_reg >= SUM_W'(rsq_reg))
            relation_next = sbc_pkg::REL_OUTSIDE;
        else if (fast_mode_reg)
            relation_next = sbc_pkg::REL_INSIDE;
        else if (lsq4_reg >= SUM_W'(rsq_reg))
            relation_next = sbc_pkg::REL_INTERSECTS;
        else
            relation_next = sbc_pkg::REL_INSIDE;
    end

    always_ff @(posedge clk)
    begin
        rsq_reg <= RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
        for (int k = 0; k < 3; k++)
        begin
            dlo1_reg[k] <= {center_reg[k][CW-1], center_reg[k]} - {lo_in[k][CW-1], lo_in[k]};
            dhi1_reg[k] <= {center_reg[k][CW-1], center_reg[k]} - {hi_in[k][CW-1], hi_in[k]};
            gap2_reg[k] <= gap2_next[k];
            far2_reg[k] <= far2_next[k];
            gsq3_reg[k] <= SQ_W'(gap2_reg[k]) * SQ_W'(gap2_reg[k]);
            fsq3_reg[k] <= SQ_W'(far2_reg[k]) * SQ_W'(far2_reg[k]);
        end
        dsq4_reg     <= SUM_W'(gsq3_reg[0]) + SUM_W'(gsq3_reg[1]) + SUM_W'(gsq3_reg[2]);
        lsq4_reg     <= SUM_W'(fsq3_reg[0]) + SUM_W'(fsq3_reg[1]) + SUM_W'(fsq3_reg[2]);
        relation_reg <= relation_next;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("result word missing five cycles after start");

    a_fast_no_intersect: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && $past(fast_mode_reg) |-> relation_reg != sbc_pkg::REL_INTERSECTS)
        else $error("intersects reported in fast mode");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && $past(rsq_reg == '0) |-> relation_reg == sbc_pkg::REL_OUTSIDE)
        else $error("zero radius must give outside");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start, 5) |-> !done)
        else $error("result word without a start");

endmodule
